[rtl/core/upsc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upsc_pkg
// Shared types and constants of the pixel replicate upscaler.
// ----------------------------------------------------------------------------
package upsc_pkg;

  localparam int SCALE_W = 6;
  localparam int WIDTH_W = 11;
  localparam int PIX_W   = 24;
  localparam int KIND_W  = 2;
  localparam int PAD_W   = 2;
  localparam int POS_W   = SCALE_W + WIDTH_W;

  localparam logic CMD_PUSH = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [KIND_W-1:0] KIND_PIX = 2'd0;
  localparam logic [KIND_W-1:0] KIND_PAD = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REJ = 2'd2;

  localparam logic REG_SCALE = 1'b0;
  localparam logic REG_WIDTH = 1'b1;

  // one burst of results for the output stage
  typedef struct packed {
    logic               reject;
    logic               use_ram;
    logic               rend;
    logic [SCALE_W-1:0] n_pix;
    logic [PAD_W-1:0]   n_pad;
    logic [PIX_W-1:0]   pix;
  } job_t;

endpackage

[rtl/core/upsc_ifs.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upsc_in_if / upsc_out_if
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface upsc_in_if;
  logic                        valid;
  logic                        ready;
  logic                        cmd;
  logic [upsc_pkg::PIX_W-1:0]  pixel;

  modport source (output valid, output cmd, output pixel, input ready);
  modport sink (input valid, input cmd, input pixel, output ready);
endinterface

interface upsc_out_if;
  logic                        valid;
  logic                        ready;
  logic [upsc_pkg::KIND_W-1:0] kind;
  logic [upsc_pkg::PIX_W-1:0]  out_pixel;
  logic                        row_end;
  logic                        run_last;

  modport source (output valid, output kind, output out_pixel, output row_end,
                  output run_last, input ready);
  modport sink (input valid, input kind, input out_pixel, input row_end,
                input run_last, output ready);
endinterface

[rtl/core/upsc_line_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upsc_line_ram
// Single-port-write, single-port-read line store with registered read data.
// ----------------------------------------------------------------------------
module upsc_line_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic                       clk,
  input  logic                       we,
  input  logic [AW-1:0]              waddr,
  input  logic [upsc_pkg::PIX_W-1:0] wdata,
  input  logic                       re,
  input  logic [AW-1:0]              raddr,
  output logic [upsc_pkg::PIX_W-1:0] rdata
);

  logic [upsc_pkg::PIX_W-1:0] mem [DEPTH];
  logic [upsc_pkg::PIX_W-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[rtl/core/upsc_ctrl.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upsc_ctrl
// Configuration, row/replay state, line store access and the sequencer that
// rebuilds the scale product and replay column after a configuration write.
// ----------------------------------------------------------------------------
module upsc_ctrl #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_SCALE = 32,
  parameter int CW        = 10
) (
  input  logic                         clk,
  input  logic                         rst_n,
  upsc_in_if.sink                      in_ch,
  input  logic                         cfg_we,
  input  logic                         cfg_addr,
  input  logic [upsc_pkg::WIDTH_W-1:0] cfg_wdata,
  input  logic                         emit_free,
  output logic                         job_valid,
  output upsc_pkg::job_t               job,
  output logic                         ram_we,
  output logic [CW-1:0]                ram_waddr,
  output logic [upsc_pkg::PIX_W-1:0]   ram_wdata,
  output logic                         ram_re,
  output logic [CW-1:0]                ram_raddr
);

  localparam int SW   = upsc_pkg::SCALE_W;
  localparam int WW   = upsc_pkg::WIDTH_W;
  localparam int PW   = upsc_pkg::POS_W;
  localparam int CNTW = $clog2(PW);

  typedef enum logic [1:0] {SQ_IDLE, SQ_CALC, SQ_MUL, SQ_DIV} seq_t;

  seq_t seq_r, seq_nxt;

  logic [SW-1:0]   scale_r, scale_nxt;
  logic [WW-1:0]   width_r, width_nxt;
  logic [SW-1:0]   eff_sc_r, eff_sc_nxt;
  logic [WW-1:0]   eff_w_r, eff_w_nxt;
  logic [PW-1:0]   prod_r, prod_nxt;
  logic [CW-1:0]   in_col_r, in_col_nxt;
  logic [SW-1:0]   rows_left_r, rows_left_nxt;
  logic [PW-1:0]   replay_pos_r, replay_pos_nxt;
  logic [PW-1:0]   idx_r, idx_nxt;
  logic [SW-1:0]   sub_r, sub_nxt;
  logic [upsc_pkg::PAD_W-1:0] pad_left_r, pad_left_nxt;
  logic [PW-1:0]   num_r, num_nxt;
  logic [SW-1:0]   rem_r, rem_nxt;
  logic [CNTW-1:0] cnt_r, cnt_nxt;

  logic                       acc;
  logic                       row_done;
  logic                       last_unit;
  logic [upsc_pkg::PAD_W-1:0] pad;
  logic [PW-1:0]              rd_col;
  logic [SW:0]                rem_sh;
  logic [SW:0]                rem_sub;
  logic                       qbit;

  assign in_ch.ready = (seq_r == SQ_IDLE) && emit_free;
  assign acc         = in_ch.valid && in_ch.ready;
  assign pad         = prod_r[upsc_pkg::PAD_W-1:0];
  assign row_done    = (PW'(in_col_r) + PW'(1)) >= PW'(eff_w_r);
  assign last_unit   = (replay_pos_r + PW'(1)) >= prod_r;
  assign rd_col      = (idx_r >= PW'(eff_w_r)) ? PW'(eff_w_r) - PW'(1) : idx_r;

  // restoring divide step, one quotient bit per cycle
  assign rem_sh  = {rem_r, num_r[PW-1]};
  assign qbit    = rem_sh >= {1'b0, eff_sc_r};
  assign rem_sub = rem_sh - {1'b0, eff_sc_r};

  always_comb begin
    seq_nxt        = seq_r;
    scale_nxt      = scale_r;
    width_nxt      = width_r;
    eff_sc_nxt     = eff_sc_r;
    eff_w_nxt      = eff_w_r;
    prod_nxt       = prod_r;
    in_col_nxt     = in_col_r;
    rows_left_nxt  = rows_left_r;
    replay_pos_nxt = replay_pos_r;
    idx_nxt        = idx_r;
    sub_nxt        = sub_r;
    pad_left_nxt   = pad_left_r;
    num_nxt        = num_r;
    rem_nxt        = rem_r;
    cnt_nxt        = cnt_r;
    job_valid      = 1'b0;
    job            = '0;
    ram_we         = 1'b0;
    ram_waddr      = in_col_r;
    ram_wdata      = in_ch.pixel;
    ram_re         = 1'b0;
    ram_raddr      = rd_col[CW-1:0];

    if (acc) begin
      if (in_ch.cmd == upsc_pkg::CMD_PUSH) begin
        job_valid = 1'b1;
        if (rows_left_r != '0) begin
          job.reject = 1'b1;
        end else begin
          ram_we    = 1'b1;
          job.n_pix = eff_sc_r;
          job.pix   = in_ch.pixel;
          if (row_done) begin
            job.n_pad      = pad;
            job.rend       = 1'b1;
            in_col_nxt     = '0;
            rows_left_nxt  = eff_sc_r - SW'(1);
            replay_pos_nxt = '0;
            idx_nxt        = '0;
            sub_nxt        = '0;
            pad_left_nxt   = '0;
          end else begin
            in_col_nxt = in_col_r + CW'(1);
          end
        end
      end else if (rows_left_r != '0) begin
        job_valid = 1'b1;
        if (pad_left_r == '0) begin
          ram_re      = 1'b1;
          job.use_ram = 1'b1;
          job.n_pix   = SW'(1);
          if (last_unit) begin
            replay_pos_nxt = '0;
            idx_nxt        = '0;
            sub_nxt        = '0;
            pad_left_nxt   = pad;
            if (pad == '0) begin
              job.rend      = 1'b1;
              rows_left_nxt = rows_left_r - SW'(1);
            end
          end else begin
            replay_pos_nxt = replay_pos_r + PW'(1);
            if (({1'b0, sub_r} + (SW+1)'(1)) >= {1'b0, eff_sc_r}) begin
              sub_nxt = '0;
              idx_nxt = idx_r + PW'(1);
            end else begin
              sub_nxt = sub_r + SW'(1);
            end
          end
        end else begin
          job.n_pad    = upsc_pkg::PAD_W'(1);
          pad_left_nxt = pad_left_r - upsc_pkg::PAD_W'(1);
          if (pad_left_r == upsc_pkg::PAD_W'(1)) begin
            job.rend      = 1'b1;
            rows_left_nxt = rows_left_r - SW'(1);
          end
        end
      end
    end

    unique case (seq_r)
      SQ_IDLE: begin
      end
      SQ_CALC: begin
        if (scale_r == '0) begin
          eff_sc_nxt = SW'(1);
        end else if (32'(scale_r) > MAX_SCALE) begin
          eff_sc_nxt = SW'(MAX_SCALE);
        end else begin
          eff_sc_nxt = scale_r;
        end
        if (width_r == '0) begin
          eff_w_nxt = WW'(1);
        end else if (32'(width_r) > MAX_WIDTH) begin
          eff_w_nxt = WW'(MAX_WIDTH);
        end else begin
          eff_w_nxt = width_r;
        end
        seq_nxt = SQ_MUL;
      end
      SQ_MUL: begin
        prod_nxt = PW'(PW'(eff_sc_r) * PW'(eff_w_r));
        num_nxt  = replay_pos_r;
        rem_nxt  = '0;
        cnt_nxt  = '0;
        seq_nxt  = SQ_DIV;
      end
      SQ_DIV: begin
        num_nxt = {num_r[PW-2:0], qbit};
        rem_nxt = qbit ? rem_sub[SW-1:0] : rem_sh[SW-1:0];
        cnt_nxt = cnt_r + CNTW'(1);
        if (cnt_r == CNTW'(PW - 1)) begin
          idx_nxt = num_nxt;
          sub_nxt = rem_nxt;
          seq_nxt = SQ_IDLE;
        end
      end
      default: seq_nxt = SQ_IDLE;
    endcase

    if (cfg_we) begin
      unique case (cfg_addr)
        upsc_pkg::REG_SCALE: scale_nxt = cfg_wdata[SW-1:0];
        upsc_pkg::REG_WIDTH: width_nxt = cfg_wdata;
        default: ;
      endcase
      seq_nxt = SQ_CALC;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seq_r        <= SQ_IDLE;
      scale_r      <= SW'(1);
      width_r      <= WW'(1);
      eff_sc_r     <= SW'(1);
      eff_w_r      <= WW'(1);
      prod_r       <= PW'(1);
      in_col_r     <= '0;
      rows_left_r  <= '0;
      replay_pos_r <= '0;
      idx_r        <= '0;
      sub_r        <= '0;
      pad_left_r   <= '0;
      cnt_r        <= '0;
    end else begin
      seq_r        <= seq_nxt;
      scale_r      <= scale_nxt;
      width_r      <= width_nxt;
      eff_sc_r     <= eff_sc_nxt;
      eff_w_r      <= eff_w_nxt;
      prod_r       <= prod_nxt;
      in_col_r     <= in_col_nxt;
      rows_left_r  <= rows_left_nxt;
      replay_pos_r <= replay_pos_nxt;
      idx_r        <= idx_nxt;
      sub_r        <= sub_nxt;
      pad_left_r   <= pad_left_nxt;
      cnt_r        <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    num_r <= num_nxt;
    rem_r <= rem_nxt;
  end

  a_replay_col_zero: assert property (@(posedge clk) disable iff (!rst_n)
    rows_left_r != '0 |-> in_col_r == '0)
    else $error("replay pending with a partial row");

  a_pad_in_replay: assert property (@(posedge clk) disable iff (!rst_n)
    pad_left_r != '0 |-> rows_left_r != '0)
    else $error("padding owed with no replay pending");

  a_sub_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    seq_r == SQ_IDLE |-> sub_r < eff_sc_r)
    else $error("replay sub position not below scale");

  a_no_ram_clash: assert property (@(posedge clk) disable iff (!rst_n)
    ram_we |-> !ram_re && rows_left_nxt == rows_left_r || row_done)
    else $error("line store written during replay");

endmodule

[rtl/core/upsc_emit.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upsc_emit
// Expands one burst into result words and holds them in the output register.
// ----------------------------------------------------------------------------
module upsc_emit (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       job_valid,
  input  upsc_pkg::job_t             job,
  input  logic [upsc_pkg::PIX_W-1:0] ram_rdata,
  output logic                       emit_free,
  upsc_out_if.source                 out_ch
);

  localparam int SW = upsc_pkg::SCALE_W;
  localparam int DW = upsc_pkg::PAD_W;

  logic                        busy_r, busy_nxt;
  upsc_pkg::job_t              job_r, job_nxt;
  logic [SW-1:0]               cnt_pix_r, cnt_pix_nxt;
  logic [DW-1:0]               cnt_pad_r, cnt_pad_nxt;
  logic                        ov_r, ov_nxt;
  logic [upsc_pkg::KIND_W-1:0] kind_r, kind_nxt;
  logic [upsc_pkg::PIX_W-1:0]  pix_r, pix_nxt;
  logic                        rend_r, rend_nxt;
  logic                        last_r, last_nxt;

  logic                        out_load;
  logic                        emit;
  logic                        u_last;
  logic [upsc_pkg::KIND_W-1:0] u_kind;
  logic [upsc_pkg::PIX_W-1:0]  u_pix;

  assign out_load  = !ov_r || out_ch.ready;
  assign emit      = busy_r && out_load;
  assign emit_free = !busy_r || (out_load && u_last);

  always_comb begin
    if (job_r.reject) begin
      u_kind = upsc_pkg::KIND_REJ;
      u_pix  = '0;
      u_last = 1'b1;
    end else if (cnt_pix_r != '0) begin
      u_kind = upsc_pkg::KIND_PIX;
      u_pix  = job_r.use_ram ? ram_rdata : job_r.pix;
      u_last = (cnt_pix_r == SW'(1)) && (cnt_pad_r == '0);
    end else begin
      u_kind = upsc_pkg::KIND_PAD;
      u_pix  = '0;
      u_last = cnt_pad_r == DW'(1);
    end
  end

  always_comb begin
    busy_nxt    = busy_r;
    job_nxt     = job_r;
    cnt_pix_nxt = cnt_pix_r;
    cnt_pad_nxt = cnt_pad_r;
    ov_nxt      = ov_r && !out_ch.ready;
    kind_nxt    = kind_r;
    pix_nxt     = pix_r;
    rend_nxt    = rend_r;
    last_nxt    = last_r;

    if (emit) begin
      ov_nxt   = 1'b1;
      kind_nxt = u_kind;
      pix_nxt  = u_pix;
      last_nxt = u_last;
      rend_nxt = u_last && job_r.rend && !job_r.reject;
      if (cnt_pix_r != '0) begin
        cnt_pix_nxt = cnt_pix_r - SW'(1);
      end else if (cnt_pad_r != '0) begin
        cnt_pad_nxt = cnt_pad_r - DW'(1);
      end
      if (u_last) begin
        busy_nxt = 1'b0;
      end
    end

    if (job_valid) begin
      busy_nxt    = 1'b1;
      job_nxt     = job;
      cnt_pix_nxt = job.n_pix;
      cnt_pad_nxt = job.n_pad;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      ov_r   <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      ov_r   <= ov_nxt;
    end
  end

  always_ff @(posedge clk) begin
    job_r     <= job_nxt;
    cnt_pix_r <= cnt_pix_nxt;
    cnt_pad_r <= cnt_pad_nxt;
    kind_r    <= kind_nxt;
    pix_r     <= pix_nxt;
    rend_r    <= rend_nxt;
    last_r    <= last_nxt;
  end

  assign out_ch.valid     = ov_r;
  assign out_ch.kind      = kind_r;
  assign out_ch.out_pixel = pix_r;
  assign out_ch.row_end   = rend_r;
  assign out_ch.run_last  = last_r;

  a_job_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    job_valid |-> emit_free)
    else $error("burst loaded over a busy emitter");

  a_busy_has_unit: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r && !job_r.reject |-> cnt_pix_r != '0 || cnt_pad_r != '0)
    else $error("emitter busy with an empty burst");

endmodule

[rtl/core/pixel_replicate_upscaler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pixel_replicate_upscaler
// Integer nearest-neighbor upscaler for 24-bit pixel rows.
// ----------------------------------------------------------------------------
// A pushed pixel is written to the line store and leaves as scale copies, one
// result word per cycle while the receiver is ready, followed at row end by
// zero padding to a four-byte multiple, so a push holds the input until its
// copies and padding have gone out. Ticks and scale-1 pushes without padding
// go at one word per cycle while the receiver is ready; a tick reads the line
// store, whose registered read data lines up with the output stage. After each
// configuration write the input is held off while the scale product is formed
// and the replay position is divided into column and sub-column, one quotient
// bit per cycle. The line store needs no clearing after reset.
// ----------------------------------------------------------------------------
module pixel_replicate_upscaler #(
  parameter int MAX_WIDTH = 1024,
  parameter int MAX_SCALE = 32
) (
  input  logic                         clk,
  input  logic                         rst_n,
  upsc_in_if.sink                      in_ch,
  upsc_out_if.source                   out_ch,
  input  logic                         cfg_we,
  input  logic                         cfg_addr,
  input  logic [upsc_pkg::WIDTH_W-1:0] cfg_wdata
);

  localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;

  logic                       emit_free;
  logic                       job_valid;
  upsc_pkg::job_t             job;
  logic                       ram_we;
  logic [CW-1:0]              ram_waddr;
  logic [upsc_pkg::PIX_W-1:0] ram_wdata;
  logic                       ram_re;
  logic [CW-1:0]              ram_raddr;
  logic [upsc_pkg::PIX_W-1:0] ram_rdata;

  upsc_ctrl #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_SCALE (MAX_SCALE),
    .CW        (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .emit_free (emit_free),
    .job_valid (job_valid),
    .job       (job),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr)
  );

  upsc_line_ram #(
    .DEPTH (MAX_WIDTH),
    .AW    (CW)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  upsc_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .job_valid (job_valid),
    .job       (job),
    .ram_rdata (ram_rdata),
    .emit_free (emit_free),
    .out_ch    (out_ch)
  );

endmodule

[tb/sv/upscale_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// upscale_checker
// Watches the input, result and register ports of the upscaler, predicts the
// result words of every accepted input word and compares them in order.
// ----------------------------------------------------------------------------
module upscale_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  upsc_in_if                           in_mon,
  upsc_out_if                          out_mon,
  input  logic                         cfg_we,
  input  logic                         cfg_addr,
  input  logic [upsc_pkg::WIDTH_W-1:0] cfg_wdata,
  output int                           mismatches,
  output int                           waiting,
  output logic                         replay_owed,
  output int                           cols_filled
);
  import upsc_pkg::*;

  localparam int MAX_COLS  = 1024;
  localparam int MAX_REPL  = 32;
  localparam int MAX_NOTES = 40;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [PIX_W-1:0]  pix;
    logic              row_end;
    logic              run_last;
  } result_word_t;

  result_word_t       owed_words[$];
  logic [PIX_W-1:0]   line_store[MAX_COLS];
  logic [SCALE_W-1:0] scale_reg;
  logic [WIDTH_W-1:0] width_reg;
  int                 in_col;
  int                 rows_left;
  int                 replay_pos;
  int                 pad_left;
  int                 filled;
  int                 fails = 0;
  int                 seen  = 0;

  function automatic int eff_scale();
    if (scale_reg == '0) return 1;
    if (int'(scale_reg) > MAX_REPL) return MAX_REPL;
    return int'(scale_reg);
  endfunction

  function automatic int eff_width();
    if (width_reg == '0) return 1;
    if (int'(width_reg) > MAX_COLS) return MAX_COLS;
    return int'(width_reg);
  endfunction

  task automatic report_mismatch(input string what);
    if (fails < MAX_NOTES) $display("[%0t] result word %0d: %s", $time, seen, what);
    fails++;
  endtask

  // expected result words of one accepted input word
  task automatic upscale_word(input logic cmd, input logic [PIX_W-1:0] pix);
    int           sc;
    int           w;
    int           npad;
    int           n;
    int           idx;
    logic         row_done;
    logic         rend;
    result_word_t r;
    sc   = eff_scale();
    w    = eff_width();
    npad = (4 - (sc * w * 3) % 4) % 4;
    if (cmd == CMD_PUSH) begin
      if (rows_left != 0) begin
        r = '{kind: KIND_REJ, pix: '0, row_end: 1'b0, run_last: 1'b1};
        owed_words.push_back(r);
        return;
      end
      line_store[in_col] = pix;
      if (in_col + 1 > filled) filled = in_col + 1;
      row_done = (in_col + 1 >= w);
      n = sc + (row_done ? npad : 0);
      for (int k = 0; k < n; k++) begin
        r.kind     = (k < sc) ? KIND_PIX : KIND_PAD;
        r.pix      = (k < sc) ? pix : '0;
        r.row_end  = row_done && (k == n - 1);
        r.run_last = (k == n - 1);
        owed_words.push_back(r);
      end
      if (row_done) begin
        in_col     = 0;
        rows_left  = sc - 1;
        replay_pos = 0;
        pad_left   = 0;
      end else begin
        in_col++;
      end
      return;
    end
    if (rows_left == 0) return;
    rend = 1'b0;
    if (pad_left == 0) begin
      idx = replay_pos / sc;
      if (idx >= w) idx = w - 1;
      if (replay_pos + 1 >= sc * w) begin
        replay_pos = 0;
        pad_left   = npad;
        if (npad == 0) begin
          rend = 1'b1;
          rows_left--;
        end
      end else begin
        replay_pos++;
      end
      r = '{kind: KIND_PIX, pix: line_store[idx], row_end: rend, run_last: 1'b1};
    end else begin
      pad_left--;
      if (pad_left == 0) begin
        rend = 1'b1;
        rows_left--;
      end
      r = '{kind: KIND_PAD, pix: '0, row_end: rend, run_last: 1'b1};
    end
    owed_words.push_back(r);
  endtask

  task automatic check_word();
    result_word_t want;
    seen++;
    if (owed_words.size() == 0) begin
      report_mismatch("word arrived with nothing expected");
      return;
    end
    want = owed_words.pop_front();
    if (out_mon.kind !== want.kind)
      report_mismatch($sformatf("kind %0d, expected %0d", out_mon.kind, want.kind));
    if (out_mon.out_pixel !== want.pix)
      report_mismatch($sformatf("pixel %h, expected %h", out_mon.out_pixel, want.pix));
    if (out_mon.row_end !== want.row_end)
      report_mismatch($sformatf("row_end %b, expected %b", out_mon.row_end, want.row_end));
    if (out_mon.run_last !== want.run_last)
      report_mismatch($sformatf("run_last %b, expected %b", out_mon.run_last, want.run_last));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      scale_reg  = SCALE_W'(1);
      width_reg  = WIDTH_W'(1);
      in_col     = 0;
      rows_left  = 0;
      replay_pos = 0;
      pad_left   = 0;
      filled     = 0;
      owed_words.delete();
    end else begin
      if (cfg_we) begin
        if (cfg_addr == REG_SCALE) scale_reg = cfg_wdata[SCALE_W-1:0];
        else width_reg = cfg_wdata;
      end
      if (in_mon.valid === 1'b1 && in_mon.ready === 1'b1) upscale_word(in_mon.cmd, in_mon.pixel);
      if (out_mon.valid === 1'b1 && out_mon.ready === 1'b1) check_word();
    end
    mismatches  <= fails;
    waiting     <= owed_words.size();
    replay_owed <= (rows_left != 0);
    cols_filled <= filled;
  end

endmodule

[tb/sv/tb_pixel_replicate_upscaler.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_pixel_replicate_upscaler
// Drives pixel pushes, replay ticks and register writes into the upscaler:
// a directed part on the corner cases, the largest scale under a long
// receiver hold, then random row sets with random gaps and receiver stalls.
// The checker does the comparing.
// ----------------------------------------------------------------------------
module tb_pixel_replicate_upscaler;
  import upsc_pkg::*;

  localparam int QUIET_LIMIT = 4000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_WAIT  = 50;
  localparam int RAND_ITEMS  = 300;

  logic               clk = 1'b0;
  logic               rst_n;
  logic               cfg_we;
  logic               cfg_addr;
  logic [WIDTH_W-1:0] cfg_wdata;
  int                 mismatches;
  int                 waiting;
  logic               replay_owed;
  int                 cols_filled;
  int                 cur_scale;
  int                 cur_width;
  int                 items;
  int                 quiet;
  bit                 calm;
  bit                 long_hold;

  upsc_in_if  in_bus();
  upsc_out_if out_bus();

  always #2 clk = ~clk;

  pixel_replicate_upscaler i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_bus),
    .out_ch    (out_bus),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  upscale_checker i_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_bus),
    .out_mon     (out_bus),
    .cfg_we      (cfg_we),
    .cfg_addr    (cfg_addr),
    .cfg_wdata   (cfg_wdata),
    .mismatches  (mismatches),
    .waiting     (waiting),
    .replay_owed (replay_owed),
    .cols_filled (cols_filled)
  );

  function automatic int idle_gap();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 55) return 0;
    if (roll < 85) return $urandom_range(1, 3);
    if (roll < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [PIX_W-1:0] rand_pixel();
    logic [31:0] r;
    r = $urandom;
    return r[PIX_W-1:0];
  endfunction

  function automatic int eff_scale(input int v);
    if (v == 0) return 1;
    if (v > 32) return 32;
    return v;
  endfunction

  function automatic int eff_width(input int v);
    if (v == 0) return 1;
    if (v > 1024) return 1024;
    return v;
  endfunction

  task automatic offer_word(input logic c, input logic [PIX_W-1:0] p);
    int gap;
    gap = calm ? 0 : idle_gap();
    if (gap > 0) begin
      in_bus.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_bus.valid <= 1'b1;
    in_bus.cmd   <= c;
    in_bus.pixel <= p;
    @(posedge clk);
    while (in_bus.ready !== 1'b1) @(posedge clk);
  endtask

  task automatic write_reg(input logic idx, input int val);
    logic [31:0] bits;
    bits = val;
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= bits[WIDTH_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    if (idx == REG_SCALE) cur_scale = val;
    else cur_width = val;
  endtask

  // wait for every owed word, then for the block to go quiet
  task automatic settle();
    in_bus.valid <= 1'b0;
    @(posedge clk);
    while (waiting != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
  endtask

  // full rows with their replays, plus stray ticks, rejected pushes and cut replays
  task automatic play_rows(input int rows, input bit breaks);
    int sc;
    int w;
    int pad;
    int ticks;
    int cut;
    sc    = eff_scale(cur_scale);
    w     = eff_width(cur_width);
    pad   = (4 - (sc * w * 3) % 4) % 4;
    ticks = (sc * w + pad) * (sc - 1);
    for (int r = 0; r < rows; r++) begin
      for (int i = 0; i < w; i++) begin
        if (items >= RAND_ITEMS) return;
        if (breaks && $urandom_range(0, 19) == 0) offer_word(CMD_TICK, rand_pixel());
        offer_word(CMD_PUSH, rand_pixel());
        items++;
      end
      cut = ticks;
      if (breaks && $urandom_range(0, 9) == 0) cut = $urandom_range(0, ticks);
      for (int i = 0; i < cut; i++) begin
        if (items >= RAND_ITEMS) return;
        if (breaks && $urandom_range(0, 49) == 0) begin
          offer_word(CMD_PUSH, rand_pixel());
          items++;
        end
        offer_word(CMD_TICK, rand_pixel());
        items++;
      end
      if (breaks) repeat ($urandom_range(0, 2)) offer_word(CMD_TICK, rand_pixel());
    end
  endtask

  task automatic random_setup();
    int sc_v;
    int w_v;
    case ($urandom_range(0, 9))
      0: begin
        sc_v = 0;
        w_v  = $urandom_range(1, 64);
      end
      1: begin
        sc_v = $urandom_range(1, 2);
        w_v  = $urandom_range(20, 64);
      end
      2: begin
        sc_v = $urandom_range(1, 8);
        w_v  = 0;
      end
      default: begin
        sc_v = $urandom_range(1, 6);
        w_v  = $urandom_range(1, 12);
      end
    endcase
    // a pending replay must not reach columns that were never filled
    if (replay_owed && eff_width(w_v) > cols_filled) w_v = cols_filled;
    write_reg(REG_SCALE, sc_v);
    write_reg(REG_WIDTH, w_v);
  endtask

  // result side: ready bursts, random stalls and one long hold on request
  initial begin
    out_bus.ready <= 1'b0;
    @(posedge clk);
    forever begin
      if (long_hold) begin
        long_hold = 1'b0;
        out_bus.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if ($urandom_range(0, 3) == 0) begin
        out_bus.ready <= 1'b0;
        repeat (idle_gap() + 1) @(posedge clk);
      end else begin
        out_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 40)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready) || cfg_we) begin
      quiet <= 0;
    end else if (quiet >= QUIET_LIMIT) begin
      $display("FAILURE");
      $finish;
    end else begin
      quiet <= quiet + 1;
    end
  end

  initial begin
    int phase;
    rst_n        <= 1'b0;
    in_bus.valid <= 1'b0;
    in_bus.cmd   <= CMD_PUSH;
    in_bus.pixel <= '0;
    cfg_we       <= 1'b0;
    cfg_addr     <= REG_SCALE;
    cfg_wdata    <= '0;
    quiet        <= 0;
    calm         = 1'b0;
    long_hold    = 1'b0;
    cur_scale    = 1;
    cur_width    = 1;
    items        = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset values, then a tick with nothing to replay
    offer_word(CMD_PUSH, 24'h000000);
    offer_word(CMD_TICK, 24'hFFFFFF);
    settle();
    // zero in both registers acts as one
    write_reg(REG_SCALE, 0);
    write_reg(REG_WIDTH, 0);
    offer_word(CMD_PUSH, 24'hFFFFFF);
    settle();
    // push during replay is rejected, stray tick after the replay
    write_reg(REG_SCALE, 2);
    write_reg(REG_WIDTH, 1);
    offer_word(CMD_PUSH, 24'hA5A5A5);
    offer_word(CMD_PUSH, 24'h5A5A5A);
    repeat (5) offer_word(CMD_TICK, 24'h000000);
    settle();
    // widest row, narrowed in the middle of the row
    write_reg(REG_SCALE, 1);
    write_reg(REG_WIDTH, 2047);
    offer_word(CMD_PUSH, 24'h123456);
    offer_word(CMD_PUSH, 24'h654321);
    settle();
    write_reg(REG_WIDTH, 3);
    offer_word(CMD_PUSH, 24'h0F0F0F);
    settle();
    // scale lowered in the middle of a replay
    write_reg(REG_SCALE, 3);
    write_reg(REG_WIDTH, 1);
    offer_word(CMD_PUSH, 24'h800001);
    repeat (2) offer_word(CMD_TICK, 24'h7FFFFE);
    settle();
    write_reg(REG_SCALE, 1);
    repeat (5) offer_word(CMD_TICK, 24'h000000);
    settle();
    // largest scale under a long receiver hold, replay finished at scale one
    write_reg(REG_SCALE, 63);
    write_reg(REG_WIDTH, 1);
    long_hold = 1'b1;
    wait (long_hold == 1'b0);
    offer_word(CMD_PUSH, rand_pixel());
    repeat (3) offer_word(CMD_TICK, rand_pixel());
    settle();
    write_reg(REG_SCALE, 1);
    repeat (62) offer_word(CMD_TICK, rand_pixel());
    settle();
    // longest push, with three padding bytes
    write_reg(REG_SCALE, 31);
    offer_word(CMD_PUSH, rand_pixel());
    settle();
    write_reg(REG_SCALE, 1);
    repeat (60) offer_word(CMD_TICK, rand_pixel());

    items = 0;
    phase = 0;
    while (items < RAND_ITEMS) begin
      settle();
      random_setup();
      calm = ($urandom_range(0, 3) == 0);
      if (phase == 0 || phase == 6) long_hold = 1'b1;
      play_rows($urandom_range(1, 3), 1'b1);
      phase++;
    end
    calm = 1'b0;
    settle();

    if (mismatches == 0 && waiting == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/upsc_pkg.sv
rtl/core/upsc_ifs.sv
rtl/core/upsc_line_ram.sv
rtl/core/upsc_ctrl.sv
rtl/core/upsc_emit.sv
rtl/core/pixel_replicate_upscaler.sv
tb/sv/upscale_checker.sv
tb/sv/tb_pixel_replicate_upscaler.sv
